// ===== rtl/core/tta_pkg.sv =====
// Shared types, constants and helpers for the timed threshold alarm monitor.
// No dependencies; used by every module under rtl/core.
package tta_pkg;

  // Current level count supported by the register layout
  localparam int MAX_LEVELS       = 4;
  localparam int NUM_LEVELS_DEF   = 4;

  localparam int FIELD_W          = 16;
  localparam int TIMER_W          = 32;
  localparam int CFG_W            = 64;
  localparam int CFG_INDEX_W      = 2;
  localparam int WORD_W           = 6;

  // Alarm word layout
  localparam int BIT_LOW_V        = 4;
  localparam int BIT_NORM_V       = 5;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CURRENT_LIMITS = 2'd0,
    REG_CURRENT_DELAYS = 2'd1,
    REG_VOLTAGE_LIMITS = 2'd2,
    REG_VOLTAGE_DELAYS = 2'd3
  } cfg_reg_t;

  // Per-transaction control handed from the top level to the update units
  typedef struct packed {
    logic sample;
    logic clear;
  } step_t;

  // Add elapsed time to a timer, saturating at all ones
  function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] t,
                                                 input logic [FIELD_W-1:0] ms);
    logic [TIMER_W:0] s;
    s = {1'b0, t} + {{(TIMER_W+1-FIELD_W){1'b0}}, ms};
    return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
  endfunction

endpackage

// ===== rtl/core/tta_level.sv =====
// One current level: persistence timer and alarm bit.
// Depends on tta_pkg (types, widths, sat_add).
module tta_level (
  input  logic                          clk,
  input  logic                          rst,
  input  tta_pkg::step_t                ctl,
  input  logic [tta_pkg::FIELD_W-1:0]   limit,
  input  logic [tta_pkg::FIELD_W-1:0]   delay,
  input  logic [tta_pkg::FIELD_W-1:0]   current,
  input  logic [tta_pkg::FIELD_W-1:0]   elapsed,
  output logic                          alarm_next
);

  logic [tta_pkg::TIMER_W-1:0] timer;
  logic [tta_pkg::TIMER_W-1:0] timer_next;
  logic [tta_pkg::TIMER_W-1:0] timer_add;
  logic                        alarm;
  logic                        sample_bit;

  // Compare reading against threshold and advance or drop the timer
  always_comb begin
    timer_add  = tta_pkg::sat_add(timer, elapsed);
    timer_next = timer;
    sample_bit = alarm;
    if (limit != '0) begin
      if (current > limit) begin
        timer_next = timer_add;
        if (timer_add > {{(tta_pkg::TIMER_W-tta_pkg::FIELD_W){1'b0}}, delay}) begin
          sample_bit = 1'b1;
        end
      end else begin
        timer_next = '0;
        sample_bit = 1'b0;
      end
    end
    alarm_next = ctl.clear ? 1'b0 : sample_bit;
  end

  // Hold timer and bit between transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      timer <= '0;
      alarm <= 1'b0;
    end else if (ctl.sample) begin
      timer <= timer_next;
      alarm <= sample_bit;
    end else if (ctl.clear) begin
      alarm <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/tta_volt.sv =====
// Low-voltage and normal-voltage alarms with mutually exclusive bits.
// Depends on tta_pkg (types, widths, sat_add).
module tta_volt (
  input  logic                          clk,
  input  logic                          rst,
  input  tta_pkg::step_t                ctl,
  input  logic [2*tta_pkg::FIELD_W-1:0] limits,
  input  logic [2*tta_pkg::FIELD_W-1:0] delays,
  input  logic [tta_pkg::FIELD_W-1:0]   voltage,
  input  logic [tta_pkg::FIELD_W-1:0]   elapsed,
  output logic [1:0]                    alarm_next   // bit 0 low, bit 1 normal
);

  localparam int PadW = tta_pkg::TIMER_W - tta_pkg::FIELD_W;

  logic [tta_pkg::TIMER_W-1:0] low_timer;
  logic [tta_pkg::TIMER_W-1:0] norm_timer;
  logic [1:0]                  alarm;

  logic [tta_pkg::FIELD_W-1:0] low_lim, norm_lim, low_dly, norm_dly;
  logic                        low_hit, low_fire, norm_hit, norm_fire;
  logic [tta_pkg::TIMER_W-1:0] low_add, norm_add;
  logic [tta_pkg::TIMER_W-1:0] low_a, norm_a, low_timer_next, norm_timer_next;
  logic [1:0]                  alarm_a, sample_bits;

  always_comb begin
    low_lim  = limits[tta_pkg::FIELD_W-1:0];
    norm_lim = limits[2*tta_pkg::FIELD_W-1:tta_pkg::FIELD_W];
    low_dly  = delays[tta_pkg::FIELD_W-1:0];
    norm_dly = delays[2*tta_pkg::FIELD_W-1:tta_pkg::FIELD_W];

    // Low voltage first: advance its timer, fire once and drop the other timer
    low_hit  = (low_lim != '0) && (voltage < low_lim);
    low_add  = tta_pkg::sat_add(low_timer, elapsed);
    low_fire = low_hit && (low_add > {{PadW{1'b0}}, low_dly}) && !alarm[0];
    low_a    = low_hit ? low_add : low_timer;
    norm_a   = low_fire ? '0 : norm_timer;
    alarm_a  = low_fire ? 2'b01 : alarm;

    // Normal voltage second, so it wins when both fire
    norm_hit  = (norm_lim != '0) && (voltage >= norm_lim);
    norm_add  = tta_pkg::sat_add(norm_a, elapsed);
    norm_fire = norm_hit && (norm_add > {{PadW{1'b0}}, norm_dly}) && !alarm_a[1];
    norm_timer_next = norm_hit ? norm_add : norm_a;
    low_timer_next  = norm_fire ? '0 : low_a;
    sample_bits     = norm_fire ? 2'b10 : alarm_a;

    alarm_next = ctl.clear ? 2'b00 : sample_bits;
  end

  // Hold timers and bits between transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      low_timer  <= '0;
      norm_timer <= '0;
      alarm      <= 2'b00;
    end else if (ctl.sample) begin
      low_timer  <= low_timer_next;
      norm_timer <= norm_timer_next;
      alarm      <= sample_bits;
    end else if (ctl.clear) begin
      alarm <= 2'b00;
    end
  end

endmodule

// ===== rtl/core/timed_threshold_alarm_monitor.sv =====
// Top level of the timed threshold alarm monitor: config registers, input and
// result registers, one tta_level per current level and the tta_volt unit.
// Depends on tta_pkg, tta_level and tta_volt.
//
// One transaction is accepted every clock while in_stall is low. A transaction
// lands in the input register, is evaluated from there against the timers and
// alarm bits once the sink is not holding a result, and its result is then
// captured in the result register, ready for the output handshake. The rate is
// set by the timer and alarm update, which feeds each transaction's state
// straight into the next. Configuration takes effect on the next evaluated
// transaction and should be written only while no transaction is in flight.
module timed_threshold_alarm_monitor #(
  parameter int NUM_LEVELS = tta_pkg::NUM_LEVELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [tta_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tta_pkg::CFG_W-1:0]         cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic [tta_pkg::FIELD_W-1:0]       elapsed_ms,
  input  logic [tta_pkg::FIELD_W-1:0]       current_reading,
  input  logic [tta_pkg::FIELD_W-1:0]       voltage_reading,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tta_pkg::WORD_W-1:0]        alarm_word,
  output logic                              alarm_changed
);

  localparam int FW = tta_pkg::FIELD_W;

  logic [tta_pkg::CFG_W-1:0]   current_limits;
  logic [tta_pkg::CFG_W-1:0]   current_delays;
  logic [2*FW-1:0]             voltage_limits;
  logic [2*FW-1:0]             voltage_delays;

  logic                        s1_valid;
  logic                        s1_op;
  logic [FW-1:0]               s1_elapsed;
  logic [FW-1:0]               s1_current;
  logic [FW-1:0]               s1_voltage;
  logic                        s1_advance;

  tta_pkg::step_t              ctl;
  logic [tta_pkg::WORD_W-1:0]  word_next;
  logic [tta_pkg::WORD_W-1:0]  prev_word;
  logic [1:0]                  volt_next;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      current_limits <= '0;
      current_delays <= '0;
      voltage_limits <= '0;
      voltage_delays <= '0;
    end else if (cfg_write) begin
      unique case (tta_pkg::cfg_reg_t'(cfg_index))
        tta_pkg::REG_CURRENT_LIMITS: current_limits <= cfg_data;
        tta_pkg::REG_CURRENT_DELAYS: current_delays <= cfg_data;
        tta_pkg::REG_VOLTAGE_LIMITS: voltage_limits <= cfg_data[2*FW-1:0];
        tta_pkg::REG_VOLTAGE_DELAYS: voltage_delays <= cfg_data[2*FW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: input stage moves on unless a result is held by the sink
  assign s1_advance = s1_valid && !(out_valid && out_stall);
  assign in_stall   = s1_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op      <= op;
      s1_elapsed <= elapsed_ms;
      s1_current <= current_reading;
      s1_voltage <= voltage_reading;
    end
  end

  assign ctl.sample = s1_advance && !s1_op;
  assign ctl.clear  = s1_advance && s1_op;

  // Current levels; unused levels stay clear
  for (genvar k = 0; k < tta_pkg::MAX_LEVELS; k++) begin : g_level
    if (k < NUM_LEVELS) begin : g_on
      tta_level u_level (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .limit      (current_limits[FW*k +: FW]),
        .delay      (current_delays[FW*k +: FW]),
        .current    (s1_current),
        .elapsed    (s1_elapsed),
        .alarm_next (word_next[k])
      );
    end else begin : g_off
      assign word_next[k] = 1'b0;
    end
  end

  tta_volt u_volt (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .limits     (voltage_limits),
    .delays     (voltage_delays),
    .voltage    (s1_voltage),
    .elapsed    (s1_elapsed),
    .alarm_next (volt_next)
  );

  assign word_next[tta_pkg::BIT_LOW_V]  = volt_next[0];
  assign word_next[tta_pkg::BIT_NORM_V] = volt_next[1];

  // Result register; previous word advances only on samples
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      prev_word <= '0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
      if (!s1_op) begin
        prev_word <= word_next;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      alarm_word    <= word_next;
      alarm_changed <= !s1_op && (word_next != prev_word);
    end
  end

endmodule
